[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low reset).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/bdv_pkg.sv]
// ----------------------------------------------------------------------------
// bdv_pkg
// Constants, types and coefficient table for the battery discharge search.
// ----------------------------------------------------------------------------
package bdv_pkg;

    // Search grid and fixed-point format
    localparam int STEPS        = 1000;
    localparam int FRAC_BITS    = 24;
    localparam int FULL_MV      = 4000;
    localparam int PERMILLE_MAX = 1000;
    localparam int SCALE_MV     = 1000;   // volts to millivolts

    // Field widths
    localparam int MV_W    = 13;
    localparam int TOL_W   = 9;
    localparam int PM_W    = 10;
    localparam int K_W     = 10;
    localparam int TDATA_W = 16;

    // Datapath widths
    localparam int ACC_W = 32;                  // Horner accumulator, signed Q8.24
    localparam int X_W   = FRAC_BITS + 1;       // x in [0, 1], unsigned
    localparam int B_W   = X_W + 1;             // signed multiplier b operand
    localparam int P_W   = ACC_W + B_W;         // product
    localparam int RND_W = P_W - FRAC_BITS;     // rounded product
    localparam int BND_W = MV_W + 2;            // signed mV bounds
    localparam int REM_W = $clog2(2 * STEPS);   // running remainders

    // Incremental steps for x = round(k * 2^F / STEPS) and round(k * 1000 / STEPS)
    localparam int X_STEP_Q  = (1 << FRAC_BITS) / STEPS;
    localparam int X_STEP_R  = (1 << FRAC_BITS) % STEPS;
    localparam int PM_STEP_Q = PERMILLE_MAX / STEPS;
    localparam int PM_STEP_R = PERMILLE_MAX % STEPS;
    localparam int HALF_STEP = STEPS / 2;

    localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(1);
    localparam logic [PM_W-1:0]  NO_MATCH_PM = PM_W'(PERMILLE_MAX);

    localparam longint unsigned COEF_SCALE = 64'd100000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FULL,
        ST_MUL,
        ST_ADD,
        ST_SCALE,
        ST_CMP
    } t_state;

    typedef enum logic [1:0] {
        MUL_C4_X,
        MUL_ACC_X,
        MUL_ACC_MV
    } t_mul_sel;

    typedef struct packed {
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_en;
        logic [1:0] stage;
    } t_mac_ctrl;

    // round(e8 * 2^F / 1e8), half away from zero
    function automatic logic signed [ACC_W-1:0] coef_fixed(input longint e8);
        longint unsigned mag;
        longint unsigned q;
        mag = (e8 < 0) ? 64'(-e8) : 64'(e8);
        q   = ((mag << FRAC_BITS) + (COEF_SCALE >> 1)) / COEF_SCALE;
        return (e8 < 0) ? ACC_W'(-q) : ACC_W'(q);
    endfunction

    // Highest power first
    localparam logic signed [ACC_W-1:0] COEF [5] = '{
        coef_fixed(-64'sd508321149),
        coef_fixed( 64'sd816962756),
        coef_fixed(-64'sd353049671),
        coef_fixed(-64'sd32954030),
        coef_fixed( 64'sd408151442)
    };

endpackage

[hdl/bdv_mac.sv]
// ----------------------------------------------------------------------------
// bdv_mac
// Shared multiplier, product register, round/add/saturate and window compare.
// ----------------------------------------------------------------------------
module bdv_mac (
    input  logic                                 i_clk,
    input  bdv_pkg::t_mac_ctrl                   i_ctrl,
    input  logic [bdv_pkg::X_W-1:0]              i_x,
    input  logic signed [bdv_pkg::BND_W-1:0]     i_lo,
    input  logic signed [bdv_pkg::BND_W-1:0]     i_hi,
    output logic                                 o_match
);

    logic signed [bdv_pkg::ACC_W-1:0]   r_acc;
    logic signed [bdv_pkg::P_W-1:0]     r_prod;

    logic signed [bdv_pkg::ACC_W-1:0]   w_a;
    logic signed [bdv_pkg::B_W-1:0]     w_b;
    logic signed [bdv_pkg::P_W-1:0]     w_prod;
    logic signed [bdv_pkg::P_W-1:0]     w_rnd_sum;
    logic signed [bdv_pkg::RND_W-1:0]   w_rnd;
    logic [2:0]                         w_coef_idx;
    logic signed [bdv_pkg::RND_W:0]     w_sum;
    logic signed [bdv_pkg::ACC_W-1:0]   w_acc_next;
    logic                               w_ovf;
    logic signed [bdv_pkg::P_W-1:0]     w_lo;
    logic signed [bdv_pkg::P_W-1:0]     w_hi;

    // operand select
    always_comb begin
        unique case (i_ctrl.mul_sel)
            bdv_pkg::MUL_C4_X: begin
                w_a = bdv_pkg::COEF[0];
                w_b = $signed({1'b0, i_x});
            end
            bdv_pkg::MUL_ACC_X: begin
                w_a = r_acc;
                w_b = $signed({1'b0, i_x});
            end
            bdv_pkg::MUL_ACC_MV: begin
                w_a = r_acc;
                w_b = bdv_pkg::B_W'(bdv_pkg::SCALE_MV);
            end
            default: begin
                w_a = r_acc;
                w_b = $signed({1'b0, i_x});
            end
        endcase
    end

    assign w_prod = w_a * w_b;

    // floor((p + 2^(F-1)) / 2^F), then add next coefficient and clamp
    assign w_rnd_sum  = r_prod + (bdv_pkg::P_W'(1) <<< (bdv_pkg::FRAC_BITS - 1));
    assign w_rnd      = $signed(w_rnd_sum[bdv_pkg::P_W-1:bdv_pkg::FRAC_BITS]);
    assign w_coef_idx = {1'b0, i_ctrl.stage} + 3'd1;
    assign w_sum      = {w_rnd[bdv_pkg::RND_W-1], w_rnd}
                      + (bdv_pkg::RND_W + 1)'(bdv_pkg::COEF[w_coef_idx]);
    assign w_ovf      = (w_sum[bdv_pkg::RND_W:bdv_pkg::ACC_W-1] != '0)
                     && (w_sum[bdv_pkg::RND_W:bdv_pkg::ACC_W-1] != '1);

    always_comb begin
        if (w_ovf) begin
            w_acc_next = w_sum[bdv_pkg::RND_W] ? {1'b1, {(bdv_pkg::ACC_W-1){1'b0}}}
                                               : {1'b0, {(bdv_pkg::ACC_W-1){1'b1}}};
        end else begin
            w_acc_next = w_sum[bdv_pkg::ACC_W-1:0];
        end
    end

    // window test on acc * 1000 against (v -/+ tol) * 2^F
    assign w_lo = bdv_pkg::P_W'($signed({i_lo, {bdv_pkg::FRAC_BITS{1'b0}}}));
    assign w_hi = bdv_pkg::P_W'($signed({i_hi, {bdv_pkg::FRAC_BITS{1'b0}}}));
    assign o_match = (r_prod >= w_lo) && (r_prod <= w_hi);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.acc_en) begin
            r_acc <= w_acc_next;
        end
    end

endmodule

[hdl/bdv_seq.sv]
// ----------------------------------------------------------------------------
// bdv_seq
// Search sequencer: step counters, Horner stage control and result register.
// ----------------------------------------------------------------------------
module bdv_seq (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_valid,
    output logic                                 o_s_ready,
    input  logic [bdv_pkg::MV_W-1:0]             i_voltage,
    input  logic [bdv_pkg::TOL_W-1:0]            i_tol,
    input  logic                                 i_match,
    output bdv_pkg::t_mac_ctrl                   o_ctrl,
    output logic [bdv_pkg::X_W-1:0]              o_x,
    output logic signed [bdv_pkg::BND_W-1:0]     o_lo,
    output logic signed [bdv_pkg::BND_W-1:0]     o_hi,
    output logic                                 o_m_valid,
    input  logic                                 i_m_ready,
    output logic [bdv_pkg::PM_W-1:0]             o_pm,
    output logic                                 o_matched
);

    bdv_pkg::t_state                    r_state, n_state;
    logic [1:0]                         r_stage, n_stage;
    logic [bdv_pkg::K_W-1:0]            r_k, n_k;
    logic [bdv_pkg::PM_W-1:0]           r_pm, n_pm;
    logic [bdv_pkg::REM_W-1:0]          r_pm_rem, n_pm_rem;
    logic [bdv_pkg::X_W-1:0]            r_xq, n_xq;
    logic [bdv_pkg::REM_W-1:0]          r_xrem, n_xrem;
    logic signed [bdv_pkg::BND_W-1:0]   r_lo, n_lo;
    logic signed [bdv_pkg::BND_W-1:0]   r_hi, n_hi;
    logic                               r_out_valid, n_out_valid;
    logic [bdv_pkg::PM_W-1:0]           r_out_pm, n_out_pm;
    logic                               r_out_matched, n_out_matched;

    logic                               w_out_free;
    logic                               w_done;
    logic [bdv_pkg::REM_W-1:0]          w_xr_sum;
    logic                               w_x_carry;
    logic [bdv_pkg::REM_W-1:0]          w_pr_sum;
    logic                               w_pm_carry;

    assign w_out_free = !r_out_valid || i_m_ready;
    assign w_done     = i_match || (r_k == bdv_pkg::K_W'(bdv_pkg::STEPS));

    // x and permille advance by quotient + remainder, no divider
    assign w_xr_sum   = r_xrem + bdv_pkg::REM_W'(bdv_pkg::X_STEP_R);
    assign w_x_carry  = w_xr_sum >= bdv_pkg::REM_W'(bdv_pkg::STEPS);
    assign w_pr_sum   = r_pm_rem + bdv_pkg::REM_W'(bdv_pkg::PM_STEP_R);
    assign w_pm_carry = w_pr_sum >= bdv_pkg::REM_W'(bdv_pkg::STEPS);

    always_comb begin
        n_state       = r_state;
        n_stage       = r_stage;
        n_k           = r_k;
        n_pm          = r_pm;
        n_pm_rem      = r_pm_rem;
        n_xq          = r_xq;
        n_xrem        = r_xrem;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_out_valid   = r_out_valid && !i_m_ready;
        n_out_pm      = r_out_pm;
        n_out_matched = r_out_matched;
        o_ctrl.mul_en  = 1'b0;
        o_ctrl.mul_sel = bdv_pkg::MUL_ACC_X;
        o_ctrl.acc_en  = 1'b0;
        o_ctrl.stage   = r_stage;

        unique case (r_state)
            bdv_pkg::ST_IDLE: begin
                if (i_s_valid) begin
                    n_stage  = 2'd0;
                    n_k      = '0;
                    n_pm     = '0;
                    n_pm_rem = bdv_pkg::REM_W'(bdv_pkg::HALF_STEP);
                    n_xq     = '0;
                    n_xrem   = bdv_pkg::REM_W'(bdv_pkg::HALF_STEP);
                    n_lo     = bdv_pkg::BND_W'(i_voltage) - bdv_pkg::BND_W'(i_tol);
                    n_hi     = bdv_pkg::BND_W'(i_voltage) + bdv_pkg::BND_W'(i_tol);
                    n_state  = (i_voltage > bdv_pkg::MV_W'(bdv_pkg::FULL_MV))
                             ? bdv_pkg::ST_FULL : bdv_pkg::ST_MUL;
                end
            end
            bdv_pkg::ST_FULL: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_pm      = '0;
                    n_out_matched = 1'b1;
                    n_state       = bdv_pkg::ST_IDLE;
                end
            end
            bdv_pkg::ST_MUL: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = (r_stage == 2'd0) ? bdv_pkg::MUL_C4_X : bdv_pkg::MUL_ACC_X;
                n_state        = bdv_pkg::ST_ADD;
            end
            bdv_pkg::ST_ADD: begin
                o_ctrl.acc_en = 1'b1;
                if (r_stage == 2'd3) begin
                    n_stage = 2'd0;
                    n_state = bdv_pkg::ST_SCALE;
                end else begin
                    n_stage = r_stage + 2'd1;
                    n_state = bdv_pkg::ST_MUL;
                end
            end
            bdv_pkg::ST_SCALE: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = bdv_pkg::MUL_ACC_MV;
                n_xq   = r_xq + bdv_pkg::X_W'(bdv_pkg::X_STEP_Q) + bdv_pkg::X_W'(w_x_carry);
                n_xrem = w_x_carry ? w_xr_sum - bdv_pkg::REM_W'(bdv_pkg::STEPS) : w_xr_sum;
                n_state = bdv_pkg::ST_CMP;
            end
            bdv_pkg::ST_CMP: begin
                if (w_done) begin
                    if (w_out_free) begin
                        n_out_valid   = 1'b1;
                        n_out_pm      = i_match ? r_pm : bdv_pkg::NO_MATCH_PM;
                        n_out_matched = i_match;
                        n_state       = bdv_pkg::ST_IDLE;
                    end
                end else begin
                    // first multiply of the next step overlaps the compare
                    o_ctrl.mul_en  = 1'b1;
                    o_ctrl.mul_sel = bdv_pkg::MUL_C4_X;
                    n_k      = r_k + bdv_pkg::K_W'(1);
                    n_pm     = r_pm + bdv_pkg::PM_W'(bdv_pkg::PM_STEP_Q)
                             + bdv_pkg::PM_W'(w_pm_carry);
                    n_pm_rem = w_pm_carry ? w_pr_sum - bdv_pkg::REM_W'(bdv_pkg::STEPS)
                                          : w_pr_sum;
                    n_state  = bdv_pkg::ST_ADD;
                end
            end
            default: begin
                n_state = bdv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdv_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage       <= n_stage;
        r_k           <= n_k;
        r_pm          <= n_pm;
        r_pm_rem      <= n_pm_rem;
        r_xq          <= n_xq;
        r_xrem        <= n_xrem;
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_out_pm      <= n_out_pm;
        r_out_matched <= n_out_matched;
    end

    assign o_s_ready = (r_state == bdv_pkg::ST_IDLE);
    assign o_x       = r_xq;
    assign o_lo      = r_lo;
    assign o_hi      = r_hi;
    assign o_m_valid = r_out_valid;
    assign o_pm      = r_out_pm;
    assign o_matched = r_out_matched;

endmodule

[hdl/battery_discharge_from_voltage.sv]
// ----------------------------------------------------------------------------
// battery_discharge_from_voltage
// Battery voltage (mV) to discharged fraction (per mille) by curve search.
// ----------------------------------------------------------------------------
// Usage notes:
//  - s_axis carries one request: the measured voltage in mV. One request is
//    in flight at a time; s_axis_tready is high only while the search is idle.
//  - m_axis returns one result per request: discharged per mille in tdata and
//    the matched flag in tuser. A finished result sits in an output register,
//    so a stalled receiver only holds the block once the next result is due.
//  - cfg channel writes the tolerance in mV (reset value 1); always ready.
//    Write it only while no request is in progress.
//  - Above 4000 mV the answer is 0, matched.
//  - Otherwise step k = 0..1000 is tried in order. Each step is a Horner
//    evaluation of the quartic on the one shared multiplier (4 multiplies,
//    each followed by a round/add/saturate state) plus one multiply by 1000
//    and a window compare; the first multiply of each later step overlaps
//    the compare of the step before. The first match at k is reported as
//    k per mille; when nothing matches the result is 1000, tuser 0.
//  - Reset (synchronous, active low) returns to idle, drops m_axis_tvalid and
//    restores the tolerance.
// ----------------------------------------------------------------------------
module battery_discharge_from_voltage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bdv_pkg::TDATA_W-1:0]        s_axis_tdata,   // [12:0] voltage_mv
    // result
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bdv_pkg::TDATA_W-1:0]        m_axis_tdata,   // [9:0] discharge_permille
    output logic [0:0]                         m_axis_tuser,   // [0] matched
    // tolerance write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bdv_pkg::TOL_W-1:0]          i_cfg_data      // tolerance_mv
);

    logic [bdv_pkg::TOL_W-1:0]          r_tol;
    bdv_pkg::t_mac_ctrl                 w_ctrl;
    logic [bdv_pkg::X_W-1:0]            w_x;
    logic signed [bdv_pkg::BND_W-1:0]   w_lo;
    logic signed [bdv_pkg::BND_W-1:0]   w_hi;
    logic                               w_match;
    logic [bdv_pkg::PM_W-1:0]           w_pm;
    logic                               w_matched;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= bdv_pkg::TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    bdv_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_voltage (s_axis_tdata[bdv_pkg::MV_W-1:0]),
        .i_tol     (r_tol),
        .i_match   (w_match),
        .o_ctrl    (w_ctrl),
        .o_x       (w_x),
        .o_lo      (w_lo),
        .o_hi      (w_hi),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_pm      (w_pm),
        .o_matched (w_matched)
    );

    bdv_mac u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_x     (w_x),
        .i_lo    (w_lo),
        .i_hi    (w_hi),
        .o_match (w_match)
    );

    assign m_axis_tdata = bdv_pkg::TDATA_W'(w_pm);
    assign m_axis_tuser = w_matched;

endmodule

[hdl/bdv_checker.sv]
// ----------------------------------------------------------------------------
// bdv_checker
// Port-level checks for battery_discharge_from_voltage, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdv_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [bdv_pkg::TDATA_W-1:0]        s_axis_tdata,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [bdv_pkg::TDATA_W-1:0]        m_axis_tdata,
    input logic [0:0]                         m_axis_tuser,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [bdv_pkg::TOL_W-1:0]          i_cfg_data
);

    // reset drops the result valid
    `ASSERT_ALWAYS(a_rst_clears_valid, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")

    // one request at a time: ready drops after each accept
    `ASSERT_CLK(a_one_in_flight, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready held after accept")

    // stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

    // a miss always reports fully discharged
    `ASSERT_CLK(a_miss_full, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == bdv_pkg::TDATA_W'(bdv_pkg::PERMILLE_MAX)), "miss not 1000")

    // per mille never exceeds full scale
    `ASSERT_CLK(a_pm_range, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata <= bdv_pkg::TDATA_W'(bdv_pkg::PERMILLE_MAX)), "per mille out of range")

endmodule

bind battery_discharge_from_voltage bdv_checker u_bdv_checker (.*);
